// ===== hw/rtl/pair_spline_potential_eval_top_assert.svh =====
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - assertion macros
// Concurrent assertion shorthands used by the top level.
// ----------------------------------------------------------------------------
`ifndef PAIR_SPLINE_POTENTIAL_EVAL_TOP_ASSERT_SVH
`define PAIR_SPLINE_POTENTIAL_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PSPE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pspe: implication check failed");

// Next-cycle implication, disabled during reset
`define PSPE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pspe: next-cycle check failed");

`endif

// ===== hw/rtl/pspe_pkg.sv =====
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - package
// Transaction types, configuration layout, queue entry and shared codes.
// ----------------------------------------------------------------------------
package pspe_pkg;

  // Atom type field is 4 bits, so at most 16 types can be addressed
  localparam int MAX_TYPES = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = 3;
  localparam int QCNT_W      = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORIGIN      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_INV_SPACING = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_USED      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT       = 4'd3;

  // Configuration reset values
  localparam logic [31:0] RST_GRID_ORIGIN      = 32'd0;
  localparam logic [31:0] RST_GRID_INV_SPACING = 32'h0100_0000;
  localparam logic [12:0] RST_POINTS_USED      = 13'd2;
  localparam logic [4:0]  RST_TYPE_COUNT       = 5'd1;

  // Operation codes carried through the queue
  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;
  localparam logic [1:0] OP_ZERO = 2'd3;

  // Fraction value 1.0 in Q1.24
  localparam logic [24:0] KNOT_ONE = 25'h100_0000;

  // Width of a spline knot address before range check
  localparam int BASE_W = 24;

  typedef struct packed {
    logic              kind;
    logic [11:0]       table_address;
    logic signed [31:0] knot_value;
    logic signed [31:0] knot_slope;
    logic [31:0]       distance;
    logic [3:0]        type_a;
    logic [3:0]        type_b;
    logic [15:0]       scale;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] energy_term;
    logic signed [31:0] force_factor;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [31:0] grid_origin;
    logic [31:0] grid_inv_spacing;
    logic [12:0] points_used;
    logic [4:0]  type_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [BASE_W-1:0] addr;
    logic [31:0]       value;
    logic [31:0]       slope;
    logic [24:0]       u;
    logic              flag;
    logic [31:0]       pair_dist;
    logic [15:0]       scale;
  } qent_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_stat_t;

endpackage

// ===== hw/rtl/pair_spline_potential_eval_top.sv =====
// Throughput: one transaction per cycle unless the output stalls; set by the
// 32-stage force divider pipeline and the single write port of the knot tables.
// Load transactions give no result. Reset (synchronous, active low) empties
// the queue and pipeline and sets configuration to defaults; tables are not
// cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - top level
// Configuration registers, front end, queue and back end of the evaluator.
// ----------------------------------------------------------------------------
`include "pair_spline_potential_eval_top_assert.svh"

module pair_spline_potential_eval_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pspe_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pspe_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pspe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  pspe_pkg::cfg_t    cfg_r;
  logic              fr_push;
  pspe_pkg::qent_t   fr_ent;
  logic [1:0]        fr_inflight;
  logic              q_pop;
  pspe_pkg::qent_t   q_head;
  pspe_pkg::q_stat_t q_stat;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_origin      <= pspe_pkg::RST_GRID_ORIGIN;
      cfg_r.grid_inv_spacing <= pspe_pkg::RST_GRID_INV_SPACING;
      cfg_r.points_used      <= pspe_pkg::RST_POINTS_USED;
      cfg_r.type_count       <= pspe_pkg::RST_TYPE_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        pspe_pkg::CFG_GRID_ORIGIN:      cfg_r.grid_origin      <= cfg_wdata;
        pspe_pkg::CFG_GRID_INV_SPACING: cfg_r.grid_inv_spacing <= cfg_wdata;
        pspe_pkg::CFG_POINTS_USED:      cfg_r.points_used      <= cfg_wdata[12:0];
        pspe_pkg::CFG_TYPE_COUNT:       cfg_r.type_count       <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // Accept only while the queue has room for every transaction in flight
  assign in_ready = (5'(q_stat.count) + 5'(fr_inflight)) < 5'(pspe_pkg::QUEUE_DEPTH);

  pspe_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_accept(in_valid && in_ready),
    .in_data  (in_data),
    .push     (fr_push),
    .push_ent (fr_ent),
    .inflight (fr_inflight)
  );

  pspe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .push_ent(fr_ent),
    .pop     (q_pop),
    .head_ent(q_head),
    .stat    (q_stat)
  );

  pspe_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_ent (q_head),
    .q_empty  (q_stat.empty),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Queue never overflows or underflows, credit covers the front stages
  `PSPE_ASSERT_IMP(a_no_overflow, clk, rst_n, fr_push && !q_pop, !q_stat.full)
  `PSPE_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty)
  `PSPE_ASSERT_IMP(a_credit, clk, rst_n, 1'b1, (5'(q_stat.count) + 5'(fr_inflight)) <= 5'(pspe_pkg::QUEUE_DEPTH))
  `PSPE_ASSERT_NXT(a_drain, clk, rst_n, q_pop && !fr_push && q_stat.count == 4'd1, q_stat.empty)

endmodule

// ===== hw/rtl/pspe_front.sv =====
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - front end
// Accepts transactions, maps distance to knot and fraction, orders the atom
// types into a spline index and classifies each transaction for the queue.
// ----------------------------------------------------------------------------
module pspe_front #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pspe_pkg::cfg_t     cfg,
  input  logic               in_accept,
  input  pspe_pkg::in_item_t in_data,
  output logic               push,
  output pspe_pkg::qent_t    push_ent,
  output logic [1:0]         inflight
);

  logic               s1_vld_r;
  pspe_pkg::in_item_t s1_item_r;

  logic               s2_vld_r;
  pspe_pkg::in_item_t s2_item_r;
  logic [63:0]        s2_t_r;
  logic               s2_below_r;
  logic               s2_tbad_r;
  logic [9:0]         s2_k_r;

  logic               s3_vld_r;
  pspe_pkg::in_item_t s3_item_r;
  logic [22:0]        s3_kp_r;
  logic [12:0]        s3_knot_r;
  logic [24:0]        s3_u_r;
  logic               s3_flag_r;
  logic               s3_tbad_r;

  // Stage 1: grid offset, product, type ordering
  logic [31:0] diff;
  logic        below;
  logic [63:0] t_prod;
  logic [3:0]  ti;
  logic [3:0]  tj;
  logic        tbad;
  logic [9:0]  nti;
  logic [9:0]  tri_cnt;
  logic [9:0]  k_idx;

  always_comb begin
    below = s1_item_r.distance < cfg.grid_origin;
    diff  = s1_item_r.distance - cfg.grid_origin;
    if (s1_item_r.type_a > s1_item_r.type_b) begin
      ti = s1_item_r.type_b;
      tj = s1_item_r.type_a;
    end else begin
      ti = s1_item_r.type_a;
      tj = s1_item_r.type_b;
    end
    tbad    = ({1'b0, tj} >= cfg.type_count) || (int'(tj) >= pspe_pkg::MAX_TYPES);
    nti     = 10'(cfg.type_count) * 10'(ti);
    tri_cnt = (10'(ti) * (10'(ti) - 10'd1)) >> 1;
    k_idx   = nti - tri_cnt + 10'(tj) - 10'(ti);
  end

  assign t_prod = 64'(diff) * 64'(cfg.grid_inv_spacing);

  // Stage 2: knot, fraction and range flag
  logic [12:0] p_eff;
  logic [12:0] pm1;
  logic [15:0] ip;
  logic [12:0] knot;
  logic [24:0] u_frac;
  logic        flag;
  logic [22:0] kp;

  always_comb begin
    p_eff = (cfg.points_used < 13'd2) ? 13'd2 : cfg.points_used;
    pm1   = p_eff - 13'd1;
    ip    = s2_t_r[63:48];
    if (s2_below_r) begin
      knot   = 13'd0;
      u_frac = 25'd0;
      flag   = 1'b1;
    end else if (ip >= 16'(pm1)) begin
      knot   = p_eff - 13'd2;
      u_frac = pspe_pkg::KNOT_ONE;
      flag   = (ip > 16'(pm1)) || (s2_t_r[47:0] != 48'd0);
    end else begin
      knot   = ip[12:0];
      u_frac = {1'b0, s2_t_r[47:24]};
      flag   = 1'b0;
    end
    kp = 23'(s2_k_r) * 23'(p_eff);
  end

  // Stage 3: knot address, range check, classify
  logic [pspe_pkg::BASE_W-1:0] base;
  logic                        base_bad;

  always_comb begin
    base     = pspe_pkg::BASE_W'(s3_kp_r) + pspe_pkg::BASE_W'(s3_knot_r);
    base_bad = base >= pspe_pkg::BASE_W'(TABLE_DEPTH - 1);
    push_ent.value     = s3_item_r.knot_value;
    push_ent.slope     = s3_item_r.knot_slope;
    push_ent.u         = s3_u_r;
    push_ent.pair_dist = s3_item_r.distance;
    push_ent.scale     = s3_item_r.scale;
    push_ent.addr      = base;
    push_ent.flag      = 1'b0;
    if (!s3_item_r.kind) begin
      push_ent.addr = pspe_pkg::BASE_W'(s3_item_r.table_address);
      if (int'(s3_item_r.table_address) < TABLE_DEPTH) begin
        push_ent.op = pspe_pkg::OP_LOAD;
      end else begin
        push_ent.op = pspe_pkg::OP_NOP;
      end
    end else if (s3_item_r.scale == 16'd0) begin
      push_ent.op = pspe_pkg::OP_ZERO;
    end else if (s3_tbad_r || base_bad) begin
      push_ent.op   = pspe_pkg::OP_ZERO;
      push_ent.flag = 1'b1;
    end else begin
      push_ent.op   = pspe_pkg::OP_EVAL;
      push_ent.flag = s3_flag_r;
    end
  end

  assign push     = s3_vld_r;
  assign inflight = 2'(s1_vld_r) + 2'(s2_vld_r) + 2'(s3_vld_r);

  // Advance valid bits every cycle; the queue credit guarantees room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    s1_item_r  <= in_data;
    s2_item_r  <= s1_item_r;
    s2_t_r     <= t_prod;
    s2_below_r <= below;
    s2_tbad_r  <= tbad;
    s2_k_r     <= k_idx;
    s3_item_r  <= s2_item_r;
    s3_kp_r    <= kp;
    s3_knot_r  <= knot;
    s3_u_r     <= u_frac;
    s3_flag_r  <= flag;
    s3_tbad_r  <= s2_tbad_r;
  end

endmodule

// ===== hw/rtl/pspe_queue.sv =====
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - transaction queue
// Short FIFO that decouples the front end from the evaluation back end.
// ----------------------------------------------------------------------------
module pspe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pspe_pkg::qent_t   push_ent,
  input  logic              pop,
  output pspe_pkg::qent_t   head_ent,
  output pspe_pkg::q_stat_t stat
);

  pspe_pkg::qent_t                 ent_r [pspe_pkg::QUEUE_DEPTH];
  logic [pspe_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [pspe_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [pspe_pkg::QCNT_W-1:0]     count_r;
  logic [pspe_pkg::QCNT_W-1:0]     count_nxt;

  assign head_ent   = ent_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == pspe_pkg::QCNT_W'(pspe_pkg::QUEUE_DEPTH));

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== hw/rtl/pspe_back.sv =====
// ----------------------------------------------------------------------------
// Pair spline potential evaluator - back end
// Holds the knot tables, evaluates the Hermite cubic and its derivative,
// scales them and divides the force term by distance in a bit pipeline.
// ----------------------------------------------------------------------------
module pspe_back #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pspe_pkg::cfg_t      cfg,
  input  pspe_pkg::qent_t     head_ent,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output pspe_pkg::out_item_t out_data
);

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int DIV_STEPS = 32;
  localparam int NS        = 6 + DIV_STEPS + 1;

  typedef struct packed {
    logic        zero;
    logic        flag;
    logic [15:0] scale;
    logic [31:0] pair_dist;
    logic [24:0] u;
  } side_t;

  typedef struct packed {
    logic [31:0] energy;
    logic        neg;
    logic        ovf;
  } tail_t;

  localparam logic signed [56:0] SAT_HI = 57'sd2147483647;
  localparam logic signed [56:0] SAT_LO = -57'sd2147483648;

  // One restoring division step: returns quotient bit and new remainder
  function automatic logic [32:0] div_step(input logic [31:0] rem,
                                           input logic        bit_in,
                                           input logic [31:0] d);
    logic [32:0] r;
    logic [32:0] sub;
    r   = {rem, bit_in};
    sub = r - {1'b0, d};
    if (r >= {1'b0, d}) begin
      return {1'b1, sub[31:0]};
    end
    return {1'b0, r[31:0]};
  endfunction

  logic [31:0] val_mem   [TABLE_DEPTH];
  logic [31:0] slope_mem [TABLE_DEPTH];

  logic            en;
  logic            wr;
  logic [AW-1:0]   ra0;
  logic [AW-1:0]   ra1;
  logic [NS-1:0]   vld_r;
  side_t           side_r [NS];
  logic            out_valid_r;
  pspe_pkg::out_item_t out_data_r;
  pspe_pkg::out_item_t res;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_empty;
  assign wr  = pop && (head_ent.op == pspe_pkg::OP_LOAD);
  assign ra0 = head_ent.addr[AW-1:0];
  assign ra1 = AW'(head_ent.addr + 1'b1);

  // Stage 0: table write and knot reads
  logic signed [31:0] rd_p0_r;
  logic signed [31:0] rd_p1_r;
  logic signed [31:0] rd_d0_r;
  logic signed [31:0] rd_d1_r;

  always_ff @(posedge clk) begin
    if (wr) begin
      val_mem[ra0]   <= head_ent.value;
      slope_mem[ra0] <= head_ent.slope;
    end
    if (en) begin
      rd_p0_r <= val_mem[ra0];
      rd_p1_r <= val_mem[ra1];
      rd_d0_r <= slope_mem[ra0];
      rd_d1_r <= slope_mem[ra1];
    end
  end

  // Stage 1: Hermite coefficients
  logic signed [39:0] p0w;
  logic signed [39:0] p1w;
  logic signed [39:0] d0w;
  logic signed [39:0] d1w;
  logic signed [39:0] zw;
  logic signed [39:0] a_r;
  logic signed [39:0] b_r;
  logic signed [39:0] p0_1_r;
  logic signed [39:0] d0_1_r;

  assign p0w = 40'(rd_p0_r);
  assign p1w = 40'(rd_p1_r);
  assign d0w = 40'(rd_d0_r);
  assign d1w = 40'(rd_d1_r);
  assign zw  = p1w - p0w;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= 40'sd3 * zw - 40'sd2 * d0w - d1w;
      b_r    <= d0w + d1w - 40'sd2 * zw;
      p0_1_r <= p0w;
      d0_1_r <= d0w;
    end
  end

  // Stage 2: first Horner step of value and derivative
  logic signed [25:0] us2;
  logic signed [65:0] ub2;
  logic signed [65:0] ubd2;
  logic signed [39:0] in1_r;
  logic signed [39:0] ind_r;
  logic signed [39:0] p0_2_r;
  logic signed [39:0] d0_2_r;

  assign us2  = {1'b0, side_r[1].u};
  assign ub2  = us2 * b_r;
  assign ubd2 = us2 * (40'sd3 * b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      in1_r  <= a_r + 40'(ub2 >>> 24);
      ind_r  <= 40'sd2 * a_r + 40'(ubd2 >>> 24);
      p0_2_r <= p0_1_r;
      d0_2_r <= d0_1_r;
    end
  end

  // Stage 3: second Horner step, derivative done
  logic signed [25:0] us3;
  logic signed [65:0] ui3;
  logic signed [65:0] uid3;
  logic signed [39:0] in2_r;
  logic signed [39:0] der_r;
  logic signed [39:0] p0_3_r;

  assign us3  = {1'b0, side_r[2].u};
  assign ui3  = us3 * in1_r;
  assign uid3 = us3 * ind_r;

  always_ff @(posedge clk) begin
    if (en) begin
      in2_r  <= d0_2_r + 40'(ui3 >>> 24);
      der_r  <= d0_2_r + 40'(uid3 >>> 24);
      p0_3_r <= p0_2_r;
    end
  end

  // Stage 4: value done, scale the derivative
  logic signed [25:0] us4;
  logic signed [65:0] ui4;
  logic signed [16:0] ss4;
  logic signed [56:0] dp4;
  logic signed [39:0] val_r;
  logic signed [41:0] sd_r;

  assign us4 = {1'b0, side_r[3].u};
  assign ui4 = us4 * in2_r;
  assign ss4 = {1'b0, side_r[3].scale};
  assign dp4 = der_r * ss4;

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= p0_3_r + 40'(ui4 >>> 24);
      sd_r  <= 42'(dp4 >>> 15);
    end
  end

  // Stage 5: scale and saturate energy, form force numerator halves
  logic signed [16:0] ss5;
  logic signed [56:0] ep5;
  logic signed [56:0] es5;
  logic [31:0]        energy5;
  logic [41:0]        mag5;
  logic [31:0]        e5_r;
  logic               n5_r;
  logic [41:0]        ph_r;
  logic [63:0]        pl_r;

  assign ss5 = {1'b0, side_r[4].scale};
  assign ep5 = val_r * ss5;
  assign es5 = ep5 >>> 15;

  always_comb begin
    if (es5 > SAT_HI) begin
      energy5 = 32'h7FFF_FFFF;
    end else if (es5 < SAT_LO) begin
      energy5 = 32'h8000_0000;
    end else begin
      energy5 = es5[31:0];
    end
    mag5 = sd_r[41] ? 42'(-sd_r) : 42'(sd_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e5_r <= energy5;
      n5_r <= sd_r[41];
      ph_r <= 42'(mag5[41:32]) * 42'(cfg.grid_inv_spacing);
      pl_r <= 64'(mag5[31:0]) * 64'(cfg.grid_inv_spacing);
    end
  end

  // Stage 6: full numerator, overflow check, start division
  logic [73:0] num6;
  logic [31:0] dv_rem_r [DIV_STEPS+1];
  logic [31:0] dv_low_r [DIV_STEPS+1];
  logic [31:0] dv_q_r   [DIV_STEPS+1];
  tail_t       dv_tl_r  [DIV_STEPS+1];

  assign num6 = (74'(ph_r) << 32) + 74'(pl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]       <= num6[63:32];
      dv_low_r[0]       <= num6[31:0];
      dv_q_r[0]         <= 32'd0;
      dv_tl_r[0].energy <= e5_r;
      dv_tl_r[0].neg    <= n5_r;
      dv_tl_r[0].ovf    <= num6[73:32] >= 42'(side_r[5].pair_dist);
    end
  end

  // Division pipeline, one quotient bit per stage
  for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_div
    logic [32:0] step;
    assign step = div_step(dv_rem_r[g-1], dv_low_r[g-1][31], side_r[5+g].pair_dist);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[g] <= step[31:0];
        dv_low_r[g] <= {dv_low_r[g-1][30:0], 1'b0};
        dv_q_r[g]   <= {dv_q_r[g-1][30:0], step[32]};
        dv_tl_r[g]  <= dv_tl_r[g-1];
      end
    end
  end

  // Saturate force, select zero results
  logic [31:0] lim;
  logic [31:0] fmag;
  logic [31:0] force_val;

  always_comb begin
    lim       = dv_tl_r[DIV_STEPS].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    fmag      = (dv_tl_r[DIV_STEPS].ovf || dv_q_r[DIV_STEPS] > lim) ? lim
                                                                    : dv_q_r[DIV_STEPS];
    force_val = dv_tl_r[DIV_STEPS].neg ? (32'd0 - fmag) : fmag;
    res.out_of_range = side_r[NS-1].flag;
    if (side_r[NS-1].zero) begin
      res.energy_term  = '0;
      res.force_factor = '0;
    end else begin
      res.energy_term  = dv_tl_r[DIV_STEPS].energy;
      res.force_factor = (side_r[NS-1].pair_dist == 32'd0) ? 32'd0 : force_val;
    end
  end

  // Advance valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NS-2:0],
                      pop && (head_ent.op == pspe_pkg::OP_EVAL ||
                              head_ent.op == pspe_pkg::OP_ZERO)};
      out_valid_r <= vld_r[NS-1];
    end
  end

  // Shift side data and hold the result register
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].zero      <= (head_ent.op == pspe_pkg::OP_ZERO);
      side_r[0].flag      <= head_ent.flag;
      side_r[0].scale     <= head_ent.scale;
      side_r[0].pair_dist <= head_ent.pair_dist;
      side_r[0].u         <= head_ent.u;
      for (int i = 1; i < NS; i++) begin
        side_r[i] <= side_r[i-1];
      end
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
